// ----- sv/pcm_fifo_audio_irq_regs_assert.svh -----
// Assertion macros for the PCM FIFO audio and IRQ register block.
`ifndef PCM_FIFO_AUDIO_IRQ_REGS_ASSERT_SVH
`define PCM_FIFO_AUDIO_IRQ_REGS_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define PFA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property whose consequent must hold in the cycle after its antecedent.
`define PFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/pcmfifo_pkg.sv -----
package pcmfifo_pkg;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  localparam logic [1:0] SUB_CLEAR  = 2'd0;
  localparam logic [1:0] SUB_PUSH   = 2'd1;
  localparam logic [1:0] SUB_PER_LO = 2'd2;
  localparam logic [1:0] SUB_PER_HI = 2'd3;

  localparam logic [3:0] REG_IRQ_LATCH = 4'd8;
  localparam logic [3:0] REG_IRQ_COUNT = 4'd9;

  // 6554 / 2^16 approximates 1/10 exactly enough for magnitudes up to 1920
  localparam logic [12:0] RECIP_TEN = 13'd6554;

  typedef enum logic [1:0] {
    LVL_KEEP,
    LVL_CLEAR,
    LVL_SET
  } lvl_op_e;

endpackage

// ----- sv/pcm_fifo_audio_irq_regs.sv -----
// An input transfer reads sample memory; the execute, divide and output states then
// update state and multiply, divide by ten and load the output register for the master
// side. New items are taken only in the idle state; a stalled output holds the last step.
// Reset: asynchronous, clears pointers, flags, timers, levels and the IRQ counter.
// The sample memories are not swept; a per-channel fill count makes unwritten
// entries read as zero, so the block takes items right after reset.
module pcm_fifo_audio_irq_regs
  import pcmfifo_pkg::*;
#(
  parameter int FIFO_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] write_data
  input  logic [5:0]  s_axis_tuser_i,   // [1:0] mode, [5:2] reg_index
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o    // [7:0] read_data, [16:8] sample_left,
                                        // [25:17] sample_right, [26] irq_line
);

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam int FW = $clog2(FIFO_DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(FIFO_DEPTH - 1);
  localparam logic [FW-1:0] FILL_MAX = FW'(FIFO_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
    if (p == PTR_LAST) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  logic [1:0] st_q, st_d;
  logic       in_xfer;
  logic       out_free;

  logic [1:0] mode_q;
  logic [3:0] idx_q;
  logic [7:0] data_q;

  logic [AW-1:0]      rd_ptr_q [2];
  logic [AW-1:0]      rd_ptr_d [2];
  logic [AW-1:0]      wr_ptr_q [2];
  logic [AW-1:0]      wr_ptr_d [2];
  logic [FW-1:0]      fill_q   [2];
  logic [FW-1:0]      fill_d   [2];
  logic [1:0]         full_q, full_d;
  logic [1:0]         empty_q, empty_d;
  logic [11:0]        period_q [2];
  logic [11:0]        period_d [2];
  logic [3:0]         gain_q   [2];
  logic [3:0]         gain_d   [2];
  logic [11:0]        cnt_q    [2];
  logic [11:0]        cnt_d    [2];
  logic signed [8:0]  level_q  [2];
  logic signed [8:0]  level_d  [2];

  logic [AW-1:0]      raddr    [2];
  logic [7:0]         rdata_q  [2];
  logic [1:0]         rvld_q;
  logic [1:0]         mem_we;
  logic [7:0]         byte_rd  [2];

  lvl_op_e            lvl_op_d [2];
  lvl_op_e            lvl_op_q [2];
  logic signed [12:0] prod_d   [2];
  logic signed [12:0] prod_q   [2];

  logic [7:0]  irq_latch_q, irq_latch_d;
  logic [14:0] irq_count_q, irq_count_d;
  logic        irq_armed_q, irq_armed_d;
  logic        irq_flag_q, irq_flag_d;

  logic [7:0]  rd_data_q, rd_data_d;
  logic        out_vld_q;
  logic [31:0] out_data_q;

  assign s_axis_tready_o = (st_q == S_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE: if (in_xfer) st_d = S_EXEC;
      S_EXEC: st_d = S_DIV;
      S_DIV:  st_d = S_OUT;
      S_OUT:  if (out_free) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  // Sample memories, one per channel
  for (genvar g = 0; g < 2; g++) begin : g_mem
    logic [7:0] mem [FIFO_DEPTH];

    assign raddr[g] = (s_axis_tuser_i[1:0] == MODE_TICK) ? ptr_next(rd_ptr_q[g]) : rd_ptr_q[g];

    always_ff @(posedge clk_i) begin
      if (mem_we[g]) begin
        mem[wr_ptr_q[g]] <= data_q;
      end
      if (in_xfer) begin
        rdata_q[g] <= mem[raddr[g]];
      end
    end

    // entries at or beyond the fill count were never written since the last clear
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rvld_q[g] <= 1'b0;
      end else if (in_xfer) begin
        rvld_q[g] <= FW'(raddr[g]) < fill_q[g];
      end
    end

    assign byte_rd[g] = rvld_q[g] ? rdata_q[g] : 8'h00;
  end

  always_comb begin
    logic          sel;
    logic [AW-1:0] nxt;
    logic [7:0]    lvl_byte;
    logic [3:0]    gain_use;
    for (int c = 0; c < 2; c++) begin
      rd_ptr_d[c] = rd_ptr_q[c];
      wr_ptr_d[c] = wr_ptr_q[c];
      fill_d[c]   = fill_q[c];
      full_d[c]   = full_q[c];
      empty_d[c]  = empty_q[c];
      period_d[c] = period_q[c];
      gain_d[c]   = gain_q[c];
      cnt_d[c]    = cnt_q[c];
      lvl_op_d[c] = LVL_KEEP;
      mem_we[c]   = 1'b0;
      nxt         = '0;
      lvl_byte    = byte_rd[c];
      gain_use    = gain_q[c];
      sel = (mode_q == MODE_WRITE) && !idx_q[3] && (idx_q[2] == 1'(c));
      if (sel) begin
        case (idx_q[1:0])
          SUB_CLEAR: begin
            rd_ptr_d[c] = '0;
            wr_ptr_d[c] = '0;
            fill_d[c]   = '0;
            full_d[c]   = 1'b0;
            empty_d[c]  = 1'b1;
            cnt_d[c]    = period_q[c];
            lvl_op_d[c] = LVL_CLEAR;
          end
          SUB_PUSH: begin
            nxt = ptr_next(wr_ptr_q[c]);
            mem_we[c] = (st_q == S_EXEC);
            if (rd_ptr_q[c] == wr_ptr_q[c]) begin
              empty_d[c]  = 1'b0;
              lvl_op_d[c] = LVL_SET;
              lvl_byte    = data_q;
              cnt_d[c]    = period_q[c];
            end
            wr_ptr_d[c] = nxt;
            if (rd_ptr_q[c] == nxt) begin
              full_d[c] = 1'b1;
            end
            if (fill_q[c] != FILL_MAX) begin
              fill_d[c] = fill_q[c] + 1'b1;
            end
          end
          SUB_PER_LO: begin
            period_d[c] = {period_q[c][11:8], data_q};
          end
          default: begin
            period_d[c] = {data_q[3:0], period_q[c][7:0]};
            gain_d[c]   = data_q[7:4];
            gain_use    = data_q[7:4];
            if (!empty_q[c]) begin
              lvl_op_d[c] = LVL_SET;
            end
          end
        endcase
      end else if ((mode_q == MODE_TICK) && !empty_q[c]) begin
        if (cnt_q[c] != '0) begin
          cnt_d[c] = cnt_q[c] - 1'b1;
        end else begin
          nxt = ptr_next(rd_ptr_q[c]);
          cnt_d[c] = period_q[c];
          if (rd_ptr_q[c] == wr_ptr_q[c]) begin
            full_d[c] = 1'b0;
          end
          rd_ptr_d[c] = nxt;
          lvl_op_d[c] = LVL_SET;
          if (nxt == wr_ptr_q[c]) begin
            empty_d[c] = 1'b1;
          end
        end
      end
      // {~b[7], b[6:0]} read as signed is b - 128
      prod_d[c] = 13'($signed({~lvl_byte[7], lvl_byte[6:0]}))
                * 13'($signed({1'b0, gain_use}));
    end
  end

  always_comb begin
    irq_latch_d = irq_latch_q;
    irq_count_d = irq_count_q;
    irq_armed_d = irq_armed_q;
    irq_flag_d  = irq_flag_q;
    rd_data_d   = 8'h00;
    case (mode_q)
      MODE_WRITE: begin
        if (idx_q == REG_IRQ_LATCH) begin
          irq_latch_d = data_q;
        end else if (idx_q == REG_IRQ_COUNT) begin
          irq_count_d = {data_q[6:0], irq_latch_q};
          irq_armed_d = data_q[7];
          irq_flag_d  = 1'b0;
        end
      end
      MODE_READ: begin
        if (idx_q[3:1] == 3'd0) begin
          rd_data_d = {full_q[idx_q[0]], empty_q[idx_q[0]], 6'd0};
        end
      end
      MODE_TICK: begin
        if (irq_armed_q && (irq_count_q != '0)) begin
          irq_count_d = irq_count_q - 1'b1;
          if (irq_count_q == 15'd1) begin
            irq_armed_d = 1'b0;
            irq_flag_d  = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Divide by ten with truncation toward zero through a reciprocal multiply
  always_comb begin
    logic        neg;
    logic [12:0] mag;
    logic [23:0] scaled;
    logic [8:0]  quo;
    for (int c = 0; c < 2; c++) begin
      neg    = prod_q[c][12];
      mag    = neg ? 13'(-prod_q[c]) : 13'(prod_q[c]);
      scaled = 24'(mag[10:0]) * 24'(RECIP_TEN);
      quo    = {1'b0, scaled[23:16]};
      level_d[c] = level_q[c];
      case (lvl_op_q[c])
        LVL_CLEAR: level_d[c] = '0;
        LVL_SET:   level_d[c] = neg ? $signed(-quo) : $signed(quo);
        default:   level_d[c] = level_q[c];
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      mode_q <= s_axis_tuser_i[1:0];
      idx_q  <= s_axis_tuser_i[5:2];
      data_q <= s_axis_tdata_i;
    end
    if (st_q == S_EXEC) begin
      prod_q    <= prod_d;
      rd_data_q <= rd_data_d;
    end
    if ((st_q == S_OUT) && out_free) begin
      out_data_q <= {5'd0, irq_flag_q, level_q[1], level_q[0], rd_data_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      out_vld_q   <= 1'b0;
      full_q      <= '0;
      empty_q     <= '1;
      irq_latch_q <= '0;
      irq_count_q <= '0;
      irq_armed_q <= 1'b0;
      irq_flag_q  <= 1'b0;
      for (int c = 0; c < 2; c++) begin
        rd_ptr_q[c] <= '0;
        wr_ptr_q[c] <= '0;
        fill_q[c]   <= '0;
        period_q[c] <= '0;
        gain_q[c]   <= '0;
        cnt_q[c]    <= '0;
        level_q[c]  <= '0;
        lvl_op_q[c] <= LVL_KEEP;
      end
    end else begin
      st_q <= st_d;
      if ((st_q == S_OUT) && out_free) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
      if (st_q == S_EXEC) begin
        full_q      <= full_d;
        empty_q     <= empty_d;
        irq_latch_q <= irq_latch_d;
        irq_count_q <= irq_count_d;
        irq_armed_q <= irq_armed_d;
        irq_flag_q  <= irq_flag_d;
        rd_ptr_q    <= rd_ptr_d;
        wr_ptr_q    <= wr_ptr_d;
        fill_q      <= fill_d;
        period_q    <= period_d;
        gain_q      <= gain_d;
        cnt_q       <= cnt_d;
        lvl_op_q    <= lvl_op_d;
      end
      if (st_q == S_DIV) begin
        level_q <= level_d;
      end
    end
  end

`include "pcm_fifo_audio_irq_regs_assert.svh"

  `PFA_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i,
                   m_axis_tvalid_o && $stable(m_axis_tdata_o), "result changed while stalled")
  `PFA_ASSERT_ALWAYS(a_fill_bound, (fill_q[0] <= FILL_MAX) && (fill_q[1] <= FILL_MAX),
                     "fill count beyond depth")
  `PFA_ASSERT_ALWAYS(a_irq_flag_disarmed, !(irq_flag_q && irq_armed_q),
                     "irq raised while counter armed")
  `PFA_ASSERT_NEXT(a_xfer_to_exec, in_xfer, (st_q == S_EXEC) && !s_axis_tready_o,
                   "accepted item not executed")

endmodule

// ----- test/tb_pcm_fifo_audio_irq_regs.sv -----
module tb_pcm_fifo_audio_irq_regs;
  import pcmfifo_pkg::*;

  localparam int PCM_DEPTH = 256;
  localparam logic [1:0] MODE_IDLE = 2'd3;
  localparam int BUS_ITEMS = 850;

  typedef struct {
    logic [1:0] mode;
    logic [3:0] idx;
    logic [7:0] data;
  } bus_item_t;

  typedef struct {
    logic [7:0]        status;
    logic signed [8:0] left;
    logic signed [8:0] right;
    logic              irq;
  } status_levels_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;   // [7:0] write_data
  logic [5:0]  s_axis_tuser_i = '0;   // [1:0] mode, [5:2] reg_index
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;        // [7:0] read_data, [16:8] sample_left,
                                      // [25:17] sample_right, [26] irq_line

  pcm_fifo_audio_irq_regs #(
    .FIFO_DEPTH(PCM_DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  bus_item_t      bus_items_q[$];
  status_levels_t status_levels_q[$];

  logic [7:0]        fifo_mem[2][PCM_DEPTH];
  int unsigned       rd_pos[2];
  int unsigned       wr_pos[2];
  logic              is_full[2];
  logic              is_empty[2];
  logic [11:0]       per_reg[2];
  logic [3:0]        gain_reg[2];
  logic [11:0]       down_cnt[2];
  logic signed [8:0] chan_lvl[2];
  logic [7:0]        irq_lo;
  logic [14:0]       irq_cnt;
  logic              irq_armed;
  logic              irq_flag;

  int mismatches;
  int useful_cnt;
  int accepted_cnt;
  int checked_cnt;
  int tick_cnt;
  int push_cnt;
  int irq_raises;
  int full_reads;

  logic in_taken;
  int   send_gap;
  int   send_calm;
  int   recv_stall;
  int   recv_calm;
  int   hold_left;
  logic held_once;

  bus_item_t      next_item;
  status_levels_t exp_r;

  function automatic logic signed [8:0] scaled_level(input logic [7:0] smp,
                                                     input logic [3:0] g);
    int prod;
    prod = (int'(smp) - 'h80) * int'(g);
    return 9'(prod / 10);
  endfunction

  function automatic int unsigned next_pos(input int unsigned p);
    return (p + 1 >= PCM_DEPTH) ? 0 : p + 1;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  task automatic chan_flush(input int ch);
    for (int i = 0; i < PCM_DEPTH; i++) fifo_mem[ch][i] = '0;
    rd_pos[ch]   = 0;
    wr_pos[ch]   = 0;
    is_full[ch]  = 1'b0;
    is_empty[ch] = 1'b1;
    down_cnt[ch] = per_reg[ch];
    chan_lvl[ch] = '0;
  endtask

  task automatic chan_reg_write(input int ch, input logic [1:0] sub, input logic [7:0] v);
    case (sub)
      SUB_CLEAR: chan_flush(ch);
      SUB_PUSH: begin
        push_cnt++;
        if (rd_pos[ch] == wr_pos[ch]) begin
          is_empty[ch] = 1'b0;
          chan_lvl[ch] = scaled_level(v, gain_reg[ch]);
          down_cnt[ch] = per_reg[ch];
        end
        fifo_mem[ch][wr_pos[ch]] = v;
        wr_pos[ch] = next_pos(wr_pos[ch]);
        if (rd_pos[ch] == wr_pos[ch]) is_full[ch] = 1'b1;
      end
      SUB_PER_LO: per_reg[ch][7:0] = v;
      default: begin
        per_reg[ch][11:8] = v[3:0];
        gain_reg[ch] = v[7:4];
        if (!is_empty[ch]) chan_lvl[ch] = scaled_level(fifo_mem[ch][rd_pos[ch]], gain_reg[ch]);
      end
    endcase
  endtask

  task automatic chan_tick(input int ch);
    if (is_empty[ch]) return;
    if (down_cnt[ch] != 0) begin
      down_cnt[ch]--;
      return;
    end
    down_cnt[ch] = per_reg[ch];
    if (rd_pos[ch] == wr_pos[ch]) is_full[ch] = 1'b0;
    rd_pos[ch] = next_pos(rd_pos[ch]);
    chan_lvl[ch] = scaled_level(fifo_mem[ch][rd_pos[ch]], gain_reg[ch]);
    if (rd_pos[ch] == wr_pos[ch]) is_empty[ch] = 1'b1;
  endtask

  task automatic step_pcm_block(input logic [1:0] mode, input logic [3:0] idx,
                                input logic [7:0] v);
    status_levels_t r;
    r.status = '0;
    case (mode)
      MODE_WRITE: begin
        if (idx < 8) chan_reg_write(int'(idx[2]), idx[1:0], v);
        else if (idx == REG_IRQ_LATCH) irq_lo = v;
        else if (idx == REG_IRQ_COUNT) begin
          irq_cnt   = {v[6:0], irq_lo};
          irq_armed = v[7];
          irq_flag  = 1'b0;
        end
      end
      MODE_READ: begin
        if (idx < 2) begin
          r.status = {is_full[idx[0]], is_empty[idx[0]], 6'b0};
          if (is_full[idx[0]]) full_reads++;
        end
      end
      MODE_TICK: begin
        tick_cnt++;
        if (irq_armed && irq_cnt != 0) begin
          irq_cnt--;
          if (irq_cnt == 0) begin
            irq_armed = 1'b0;
            irq_flag  = 1'b1;
            irq_raises++;
          end
        end
        chan_tick(0);
        chan_tick(1);
      end
      default: ;
    endcase
    r.left  = chan_lvl[0];
    r.right = chan_lvl[1];
    r.irq   = irq_flag;
    status_levels_q.push_back(r);
  endtask

  task automatic add_item(input logic [1:0] mode, input logic [3:0] idx, input logic [7:0] v);
    bus_item_t it;
    it.mode = mode;
    it.idx  = idx;
    it.data = v;
    bus_items_q.push_back(it);
    if (!(mode == MODE_IDLE || (mode == MODE_WRITE && idx > REG_IRQ_COUNT))) useful_cnt++;
  endtask

  task automatic chan_wr(input int ch, input logic [1:0] sub, input logic [7:0] v);
    add_item(MODE_WRITE, {1'b0, 1'(ch), sub}, v);
  endtask

  task automatic fill_seq();
    int ch;
    ch = $urandom_range(1);
    chan_wr(ch, SUB_CLEAR, 8'($urandom));
    chan_wr(ch, SUB_PER_LO, 8'h00);
    chan_wr(ch, SUB_PER_HI, {4'($urandom_range(15, 1)), 4'h0});
    repeat (PCM_DEPTH + 2) chan_wr(ch, SUB_PUSH, 8'($urandom));
    add_item(MODE_READ, 4'(ch), 8'($urandom));
    repeat (6) add_item(MODE_TICK, 4'($urandom), 8'($urandom));
    add_item(MODE_READ, 4'(ch), 8'($urandom));
  endtask

  task automatic play_seq();
    int ch;
    ch = $urandom_range(1);
    if ($urandom_range(1)) chan_wr(ch, SUB_CLEAR, 8'($urandom));
    chan_wr(ch, SUB_PER_LO, ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(4)));
    chan_wr(ch, SUB_PER_HI, {4'($urandom), ($urandom_range(7) == 0) ? 4'($urandom) : 4'h0});
    repeat ($urandom_range(8, 1)) chan_wr(ch, SUB_PUSH, 8'($urandom));
    repeat ($urandom_range(30, 1)) begin
      case ($urandom_range(9))
        0: add_item(MODE_READ, 4'($urandom_range(1)), 8'($urandom));
        1: chan_wr(ch, SUB_PUSH, 8'($urandom));
        2: chan_wr($urandom_range(1), SUB_PER_HI, {4'($urandom), 4'h0});
        default: add_item(MODE_TICK, 4'($urandom), 8'($urandom));
      endcase
    end
  endtask

  task automatic irq_seq();
    int lo;
    lo = ($urandom_range(4) == 0) ? $urandom_range(255) : $urandom_range(12);
    add_item(MODE_WRITE, REG_IRQ_LATCH, 8'(lo));
    add_item(MODE_WRITE, REG_IRQ_COUNT,
             {1'($urandom_range(4) != 0), ($urandom_range(7) == 0) ? 7'($urandom) : 7'h0});
    repeat (((lo > 40) ? 40 : lo) + $urandom_range(3)) begin
      if ($urandom_range(5) == 0) add_item(MODE_READ, 4'($urandom_range(1)), 8'($urandom));
      else add_item(MODE_TICK, 4'($urandom), 8'($urandom));
    end
  endtask

  always @(posedge clk_i) begin
    in_taken = rst_ni && s_axis_tvalid_i && (s_axis_tready_o === 1'b1);
    if (in_taken) begin
      accepted_cnt++;
      step_pcm_block(s_axis_tuser_i[1:0], s_axis_tuser_i[5:2], s_axis_tdata_i);
    end
    if (rst_ni && m_axis_tvalid_o === 1'b1 && m_axis_tready_i) begin
      if (status_levels_q.size() == 0) begin
        $error("result with nothing expected: tdata %h", m_axis_tdata_o);
        mismatches++;
      end else begin
        exp_r = status_levels_q.pop_front();
        checked_cnt++;
        if (m_axis_tdata_o[7:0] !== exp_r.status) begin
          $error("read_data expected %h actual %h", exp_r.status, m_axis_tdata_o[7:0]);
          mismatches++;
        end
        if (m_axis_tdata_o[16:8] !== exp_r.left) begin
          $error("sample_left expected %0d actual %0d", exp_r.left,
                 $signed(m_axis_tdata_o[16:8]));
          mismatches++;
        end
        if (m_axis_tdata_o[25:17] !== exp_r.right) begin
          $error("sample_right expected %0d actual %0d", exp_r.right,
                 $signed(m_axis_tdata_o[25:17]));
          mismatches++;
        end
        if (m_axis_tdata_o[26] !== exp_r.irq) begin
          $error("irq_line expected %b actual %b", exp_r.irq, m_axis_tdata_o[26]);
          mismatches++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid_i || in_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid_i <= 1'b0;
      end else if (bus_items_q.size() > 0) begin
        next_item = bus_items_q.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= next_item.data;
        s_axis_tuser_i  <= {next_item.idx, next_item.mode};
        if (send_calm > 0) begin
          send_calm--;
          send_gap = 0;
        end else begin
          send_gap = idle_len();
          if ($urandom_range(49) == 0) send_calm = $urandom_range(80, 20);
        end
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (!held_once && checked_cnt >= 200) begin
      held_once = 1'b1;
      hold_left = 300;
      m_axis_tready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
      if (recv_calm > 0) begin
        recv_calm--;
      end else if ($urandom_range(99) < 15) begin
        recv_stall = idle_len();
      end else if ($urandom_range(49) == 0) begin
        recv_calm = $urandom_range(80, 20);
      end
    end
  end

  initial begin
    mismatches = 0;
    held_once  = 1'b0;
    in_taken   = 1'b0;
    for (int ch = 0; ch < 2; ch++) begin
      per_reg[ch]  = '0;
      gain_reg[ch] = '0;
      chan_flush(ch);
    end
    irq_lo    = '0;
    irq_cnt   = '0;
    irq_armed = 1'b0;
    irq_flag  = 1'b0;

    add_item(MODE_READ, 4'd0, 8'h00);
    add_item(MODE_TICK, 4'd0, 8'h00);
    chan_wr(0, SUB_PER_HI, 8'hF0);
    chan_wr(0, SUB_PER_LO, 8'h02);
    chan_wr(0, SUB_PUSH, 8'h00);
    chan_wr(0, SUB_PUSH, 8'hFF);
    add_item(MODE_READ, 4'd0, 8'hFF);
    repeat (4) add_item(MODE_TICK, 4'hF, 8'hFF);
    chan_wr(1, SUB_PER_LO, 8'h00);
    chan_wr(1, SUB_PER_HI, 8'h5F);
    chan_wr(1, SUB_PUSH, 8'h80);
    chan_wr(1, SUB_PUSH, 8'h7F);
    chan_wr(1, SUB_PER_HI, 8'hA0);
    add_item(MODE_WRITE, REG_IRQ_LATCH, 8'h03);
    add_item(MODE_WRITE, REG_IRQ_COUNT, 8'h80);
    repeat (3) add_item(MODE_TICK, 4'd1, 8'h55);
    add_item(MODE_WRITE, REG_IRQ_COUNT, 8'h7F);
    add_item(MODE_WRITE, 4'hF, 8'hFF);
    add_item(MODE_READ, 4'd9, 8'h00);
    add_item(MODE_IDLE, 4'd0, 8'h00);
    chan_wr(0, SUB_CLEAR, 8'h00);
    add_item(MODE_READ, 4'd1, 8'h00);

    fill_seq();
    while (useful_cnt < BUS_ITEMS) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: play_seq();
        5, 6: irq_seq();
        7: repeat ($urandom_range(4, 1))
             add_item(2'($urandom), 4'($urandom), 8'($urandom));
        default: begin
          chan_wr($urandom_range(1), SUB_CLEAR, 8'($urandom));
          add_item(MODE_READ, 4'($urandom_range(1)), 8'($urandom));
        end
      endcase
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (bus_items_q.size() == 0 && !s_axis_tvalid_i);
    wait (status_levels_q.size() == 0);
    repeat (20) @(posedge clk_i);

    $display("Covered %0d transfers in and %0d results checked, with a 300-cycle output hold",
             accepted_cnt, checked_cnt);
    $display("  %0d ticks, %0d pushes, %0d IRQ raises, %0d status reads of a full FIFO",
             tick_cnt, push_cnt, irq_raises, full_reads);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #1600000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/pcmfifo_pkg.sv
sv/pcm_fifo_audio_irq_regs.sv
test/tb_pcm_fifo_audio_irq_regs.sv
